// File: hdl/dtt_pkg.sv
`default_nettype none

package dtt_pkg;

  localparam int TimeW    = 32;
  localparam int CountW   = 32;
  localparam int RpmW     = 26;
  localparam int TenthsW  = 30;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;
  localparam int MulW     = TimeW + RpmW;

  // command codes
  localparam logic [CmdW-1:0] CMD_PULSE    = 2'd0;
  localparam logic [CmdW-1:0] CMD_SNAPSHOT = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR    = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT    = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_MIN = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_MAX = 8'd3;

  localparam logic [TimeW-1:0] DebounceRst = 32'd1000;
  localparam logic [TimeW-1:0] TimeoutRst  = 32'd1000000;
  localparam logic [RpmW-1:0]  TargetMinRst = 26'd1000;
  localparam logic [RpmW-1:0]  TargetMaxRst = 26'd3000;

  // 60e6 rpm-microseconds; tenths use ten times that
  localparam logic [RpmW-1:0]    RpmNum       = 26'd60000000;
  localparam logic [TenthsW-1:0] RpmTenthsNum = 30'd600000000;

  localparam int DivSteps = TenthsW;
  localparam int DivCntW  = $clog2(DivSteps);

endpackage

`default_nettype wire

// File: hdl/dtt_if.sv
`default_nettype none

interface dtt_req_if import dtt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [TimeW-1:0]   time_us;
  logic               clear_pending;

  modport source (output valid, command, time_us, clear_pending, input ready);
  modport sink   (input valid, command, time_us, clear_pending, output ready);
endinterface

interface dtt_rsp_if import dtt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                pulse_accepted;
  logic [TimeW-1:0]    last_pulse_us;
  logic [TimeW-1:0]    period_avg_us;
  logic [CountW-1:0]   pulse_total;
  logic [CountW-1:0]   reject_total;
  logic                event_pending;
  logic                speed_recent;
  logic [TenthsW-1:0]  rpm_tenths;
  logic                in_target;

  modport source (output valid, pulse_accepted, last_pulse_us, period_avg_us, pulse_total,
                  reject_total, event_pending, speed_recent, rpm_tenths, in_target,
                  input ready);
  modport sink   (input valid, pulse_accepted, last_pulse_us, period_avg_us, pulse_total,
                  reject_total, event_pending, speed_recent, rpm_tenths, in_target,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/dtt_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle: RpmTenthsNum / divisor.
module dtt_div import dtt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [TimeW-1:0]   divisor,
  output logic                    done,
  output logic [TenthsW-1:0]      quotient
);

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [TimeW-1:0]   rem;
  logic [TimeW-1:0]   dvs;
  logic [TenthsW-1:0] qd;    // dividend bits out at the top, quotient bits in at the bottom

  logic [TimeW:0]     shifted;
  logic [TimeW+1:0]   diff;
  logic               qbit;
  logic [TimeW-1:0]   rem_next;

  always_comb begin
    shifted  = {rem, qd[TenthsW-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs};
    qbit     = ~diff[TimeW+1];
    rem_next = qbit ? diff[TimeW-1:0] : shifted[TimeW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= divisor;
        qd   <= RpmTenthsNum;
      end else if (busy) begin
        rem <= rem_next;
        qd  <= {qd[TenthsW-2:0], qbit};
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = qd;

endmodule

`default_nettype wire

// File: hdl/debounced_tachometer_tracker.sv
`default_nettype none

// Debounced tachometer tracker.
// Requests come in on req (command, time_us, clear_pending); every request
// gives exactly one snapshot on rsp. Commands: pulse (debounced against the
// last accepted pulse, updates the averaged period and counters), snapshot
// (optionally acks the pending flag after reporting) and clear (zeroes state).
// Registers are written through cfg_we/cfg_index/cfg_data, one per cycle;
// the user must write them only while no request is in flight, as the block
// itself does not enforce it. A request whose speed is current and period
// known runs S_UPD, S_CHK, S_DIV (the rpm quotient from a restoring divider
// that retires one bit per cycle), then S_MULMIN and S_MULMAX, two passes
// through a single multiplier for the target band check, and S_DONE. Stale or
// unknown speed skips the divider and multiplier. req.ready is high only while
// the sequencer is idle and returns the cycle after the result is loaded,
// so a new request is taken only once the last one's result is loaded.
// The result sits in an output register; if rsp is stalled the next request
// is still taken and computed, and waits only when its own result is ready.
// Synchronous reset restores the register defaults, zeroes all tracker
// state and drops rsp.valid.
module debounced_tachometer_tracker import dtt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  dtt_req_if.sink                   req,
  dtt_rsp_if.source                 rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_CHK, S_DIV, S_MULMIN, S_MULMAX, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [TimeW-1:0] debounce_us;
  logic [TimeW-1:0] recent_timeout_us;
  logic [RpmW-1:0]  band_lo_rpm;
  logic [RpmW-1:0]  band_hi_rpm;

  // tracker state
  logic [TimeW-1:0]  last_pulse_time;
  logic [TimeW-1:0]  period_average;
  logic [CountW-1:0] accepted_count;
  logic [CountW-1:0] rejected_count;
  logic              pending_flag;

  // captured request and working results
  logic [CmdW-1:0]    cmd_q;
  logic [TimeW-1:0]   now_q;
  logic               clr_q;
  logic               acc_q;
  logic               pend_q;
  logic               recent_q;
  logic [TenthsW-1:0] tenths_q;
  logic               band_q;

  // output register
  logic               out_valid;
  logic               o_acc;
  logic [TimeW-1:0]   o_last;
  logic [TimeW-1:0]   o_period;
  logic [CountW-1:0]  o_total;
  logic [CountW-1:0]  o_reject;
  logic               o_pend;
  logic               o_recent;
  logic [TenthsW-1:0] o_tenths;
  logic               o_band;

  // datapath
  logic [TimeW-1:0]   delta;
  logic               pass;
  logic [TimeW+1:0]   avg_sum;
  logic               recent;
  logic               div_start;
  logic               div_done;
  logic [TenthsW-1:0] div_q;
  logic [RpmW-1:0]    mul_op;
  logic [MulW-1:0]    mul_prod;
  logic               out_load;

  always_comb begin
    // same subtraction serves debounce (UPD) and age (CHK)
    delta   = now_q - last_pulse_time;
    pass    = (last_pulse_time == '0) || (delta >= debounce_us);
    // 3*old + delta, floored /4 below
    avg_sum = {2'b00, period_average} + {1'b0, period_average, 1'b0} + {2'b00, delta};
    recent  = (last_pulse_time != '0) && (delta <= recent_timeout_us);
    div_start = (state == S_CHK) && recent && (period_average != '0);
    // one multiplier, min bound then max bound
    mul_op   = (state == S_MULMIN) ? band_lo_rpm : band_hi_rpm;
    mul_prod = MulW'(mul_op) * MulW'(period_average);
    out_load = (state == S_DONE) && (!out_valid || rsp.ready);
  end

  dtt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (period_average),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us       <= DebounceRst;
      recent_timeout_us <= TimeoutRst;
      band_lo_rpm       <= TargetMinRst;
      band_hi_rpm       <= TargetMaxRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_us       <= cfg_data[TimeW-1:0];
        CFG_TIMEOUT:    recent_timeout_us <= cfg_data[TimeW-1:0];
        CFG_TARGET_MIN: band_lo_rpm       <= cfg_data[RpmW-1:0];
        CFG_TARGET_MAX: band_hi_rpm       <= cfg_data[RpmW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      last_pulse_time <= '0;
      period_average  <= '0;
      accepted_count  <= '0;
      rejected_count  <= '0;
      pending_flag    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        o_acc     <= acc_q;
        o_last    <= last_pulse_time;
        o_period  <= period_average;
        o_total   <= accepted_count;
        o_reject  <= rejected_count;
        o_pend    <= pend_q;
        o_recent  <= recent_q;
        o_tenths  <= tenths_q;
        o_band    <= band_q;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q <= req.command;
            now_q <= req.time_us;
            clr_q <= req.clear_pending;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          acc_q <= (cmd_q == CMD_PULSE) && pass;
          priority if (cmd_q == CMD_PULSE) begin
            if (pass) begin
              last_pulse_time <= now_q;
              if (last_pulse_time != '0) begin
                period_average <= (period_average == '0) ? delta : avg_sum[TimeW+1:2];
              end
              accepted_count <= accepted_count + 1'b1;
              pending_flag   <= 1'b1;
            end else begin
              rejected_count <= rejected_count + 1'b1;
            end
          end else if (cmd_q == CMD_CLEAR) begin
            last_pulse_time <= '0;
            period_average  <= '0;
            accepted_count  <= '0;
            rejected_count  <= '0;
            pending_flag    <= 1'b0;
          end else begin
          end
          state <= S_CHK;
        end
        S_CHK: begin
          // report pending before the snapshot ack takes effect
          pend_q   <= pending_flag;
          if ((cmd_q == CMD_SNAPSHOT) && clr_q) begin
            pending_flag <= 1'b0;
          end
          recent_q <= recent;
          if (div_start) begin
            state <= S_DIV;
          end else begin
            tenths_q <= '0;
            band_q   <= (band_lo_rpm == '0);
            state    <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            tenths_q <= div_q;
            state    <= S_MULMIN;
          end
        end
        S_MULMIN: begin
          band_q <= (mul_prod <= MulW'(RpmNum));
          state  <= S_MULMAX;
        end
        S_MULMAX: begin
          band_q <= band_q && (mul_prod >= MulW'(RpmNum));
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.pulse_accepted = o_acc;
  assign rsp.last_pulse_us  = o_last;
  assign rsp.period_avg_us  = o_period;
  assign rsp.pulse_total    = o_total;
  assign rsp.reject_total   = o_reject;
  assign rsp.event_pending  = o_pend;
  assign rsp.speed_recent   = o_recent;
  assign rsp.rpm_tenths     = o_tenths;
  assign rsp.in_target      = o_band;

endmodule

`default_nettype wire

// File: hdl/dtt_checker.sv
`default_nettype none

module dtt_checker import dtt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               rsp_pulse_accepted,
  input wire logic [TimeW-1:0]   rsp_period_avg_us,
  input wire logic               rsp_event_pending,
  input wire logic               rsp_speed_recent,
  input wire logic [TenthsW-1:0] rsp_rpm_tenths
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rpm_tenths)
      && $stable(rsp_period_avg_us))
    else $error("response changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready held after request accepted");

  a_pend: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_pulse_accepted |-> rsp_event_pending)
    else $error("accepted pulse without pending flag");

  a_rpm_recent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_speed_recent |-> rsp_rpm_tenths == '0)
    else $error("rpm reported for stale speed");

  a_rpm_period: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_period_avg_us == '0) |-> rsp_rpm_tenths == '0)
    else $error("rpm reported with unknown period");

endmodule

bind debounced_tachometer_tracker dtt_checker u_dtt_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_pulse_accepted (rsp.pulse_accepted),
  .rsp_period_avg_us  (rsp.period_avg_us),
  .rsp_event_pending  (rsp.event_pending),
  .rsp_speed_recent   (rsp.speed_recent),
  .rsp_rpm_tenths     (rsp.rpm_tenths)
);

`default_nettype wire

// File: tb/tb_debounced_tachometer_tracker.sv
module tb_debounced_tachometer_tracker;
  import dtt_pkg::*;

  // Worst case from request acceptance to rsp.valid (divider plus band check).
  localparam int ResultLatency = 36;
  // Far above the slowest legal run (~700 requests).
  localparam int unsigned CycleLimit = 500000;
  // Receiver hold-off long enough that the block fills and drops req.ready.
  localparam int HoldCycles = 300;
  localparam int BatchRequests = 100;
  localparam int NumSettings = 6;

  // Command code 3 has no meaning; the block must treat it as a plain snapshot.
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  // Register index with no register behind it; a write must change nothing.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 8'hFF;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [TimeW-1:0] time_us;
    logic             clear_pending;
  } tach_req_t;

  typedef struct packed {
    logic               pulse_accepted;
    logic [TimeW-1:0]   last_pulse_us;
    logic [TimeW-1:0]   period_avg_us;
    logic [CountW-1:0]  pulse_total;
    logic [CountW-1:0]  reject_total;
    logic               event_pending;
    logic               speed_recent;
    logic [TenthsW-1:0] rpm_tenths;
    logic               in_target;
  } tach_snap_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dtt_req_if req_ch ();
  dtt_rsp_if rsp_ch ();

  debounced_tachometer_tracker u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker shadow: register copy and state, advanced once per accepted request.
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0]  cfg_debounce;
  logic [TimeW-1:0]  cfg_timeout;
  logic [RpmW-1:0]   cfg_rpm_min;
  logic [RpmW-1:0]   cfg_rpm_max;

  logic [TimeW-1:0]  trk_last;
  logic [TimeW-1:0]  trk_period;
  logic [CountW-1:0] trk_accepts;
  logic [CountW-1:0] trk_rejects;
  logic              trk_pending;

  tach_req_t  request_q[$];    // requests waiting for the driver
  tach_snap_t snapshot_q[$];   // snapshots owed by the block, oldest first

  int mismatches = 0;
  int n_requests = 0;
  int n_accepted = 0;
  int n_rejected = 0;
  int n_current = 0;
  int n_in_band = 0;
  int n_results = 0;

  // Applies one request to the shadow state and queues the snapshot it owes.
  function automatic void track_request(tach_req_t r);
    tach_snap_t       s;
    logic [TimeW-1:0] delta;
    logic [TimeW-1:0] age;
    logic [63:0]      blend;
    s = '0;
    delta = r.time_us - trk_last;
    if (r.command == CMD_PULSE) begin
      // stored time 0 means "no pulse yet": no debounce, no period update
      if (trk_last == '0 || delta >= cfg_debounce) begin
        if (trk_last != '0) begin
          if (trk_period == '0) begin
            trk_period = delta;
          end else begin
            blend = 64'(trk_period) * 64'd3 + 64'(delta);
            trk_period = blend[33:2];
          end
        end
        trk_last = r.time_us;
        trk_accepts = trk_accepts + 1'b1;
        trk_pending = 1'b1;
        s.pulse_accepted = 1'b1;
        n_accepted++;
      end else begin
        trk_rejects = trk_rejects + 1'b1;
        n_rejected++;
      end
    end else if (r.command == CMD_CLEAR) begin
      trk_last = '0;
      trk_period = '0;
      trk_accepts = '0;
      trk_rejects = '0;
      trk_pending = 1'b0;
    end
    s.last_pulse_us = trk_last;
    s.period_avg_us = trk_period;
    s.pulse_total = trk_accepts;
    s.reject_total = trk_rejects;
    s.event_pending = trk_pending;
    age = r.time_us - trk_last;
    s.speed_recent = (trk_last != '0) && (age <= cfg_timeout);
    if (s.speed_recent && trk_period != '0) begin
      // exact rational rpm = 60e6/period, compared by cross-multiplication
      s.rpm_tenths = TenthsW'(64'(RpmTenthsNum) / 64'(trk_period));
      s.in_target = (64'(cfg_rpm_min) * 64'(trk_period) <= 64'(RpmNum)) &&
                    (64'(cfg_rpm_max) * 64'(trk_period) >= 64'(RpmNum));
      n_current++;
      if (s.in_target) n_in_band++;
    end else begin
      s.in_target = (cfg_rpm_min == '0);
    end
    // the ack lands after the snapshot has reported the flag
    if (r.command == CMD_SNAPSHOT && r.clear_pending) trk_pending = 1'b0;
    n_requests++;
    snapshot_q.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Idle control. The main sequence sets the percentages per phase; a bump of
  // hold_seq makes the ready process start the long hold-off on its own count.
  // ---------------------------------------------------------------------------
  int send_idle_pct = 21;
  int recv_idle_pct = 66;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Driver: keeps valid high across back-to-back requests; the shadow is
  // advanced at the edge where the request is taken.
  tach_req_t drv_item;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) track_request(drv_item);
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = request_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.command <= drv_item.command;
        req_ch.time_us <= drv_item.time_us;
        req_ch.clear_pending <= drv_item.clear_pending;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus the long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HoldCycles;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", fname, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: every taken result is matched against the oldest owed snapshot.
  tach_snap_t want_snap;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (snapshot_q.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want_snap = snapshot_q.pop_front();
        n_results++;
        check_field("pulse_accepted", want_snap.pulse_accepted, rsp_ch.pulse_accepted);
        check_field("last_pulse_us", want_snap.last_pulse_us, rsp_ch.last_pulse_us);
        check_field("period_avg_us", want_snap.period_avg_us, rsp_ch.period_avg_us);
        check_field("pulse_total", want_snap.pulse_total, rsp_ch.pulse_total);
        check_field("reject_total", want_snap.reject_total, rsp_ch.reject_total);
        check_field("event_pending", want_snap.event_pending, rsp_ch.event_pending);
        check_field("speed_recent", want_snap.speed_recent, rsp_ch.speed_recent);
        check_field("rpm_tenths", want_snap.rpm_tenths, rsp_ch.rpm_tenths);
        check_field("in_target", want_snap.in_target, rsp_ch.in_target);
      end
    end
  end

  // Watchdog.
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[debounced_tachometer_tracker] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] gen_time;   // running timestamp of the last generated pulse

  task automatic push_req(logic [CmdW-1:0] cmd, logic [TimeW-1:0] t, logic clr);
    tach_req_t r;
    r.command = cmd;
    r.time_us = t;
    r.clear_pending = clr;
    request_q.push_back(r);
  endtask

  // Pulse spacing around the debounce edge and across the target band
  // (20..60 ms is 3000..1000 rpm), plus stale and arbitrary gaps.
  function automatic logic [TimeW-1:0] pulse_gap();
    case ($urandom_range(9))
      0:       return cfg_debounce - 1'b1;
      1:       return cfg_debounce;
      2:       return cfg_debounce + $urandom_range(50);
      3, 4, 5: return $urandom_range(60000, 20000);
      6:       return $urandom_range(3000, 600);
      7:       return $urandom_range(2000000, 100000);
      8:       return $urandom;
      default: return $urandom_range(999);
    endcase
  endfunction

  // Snapshot offset from the last pulse attempt; hits the timeout edge exactly.
  function automatic logic [TimeW-1:0] snapshot_offset();
    case ($urandom_range(5))
      3:       return cfg_timeout;
      4:       return cfg_timeout + 1'b1;
      5:       return $urandom;
      default: return $urandom_range(5000);
    endcase
  endfunction

  // Mostly well-formed pulse trains with queries in between; clears, the
  // unused code and pulses at random times are the noise.
  function automatic tach_req_t random_request();
    tach_req_t   r;
    int unsigned pick;
    r.clear_pending = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 60) begin
      r.command = CMD_PULSE;
      gen_time = gen_time + pulse_gap();
      r.time_us = gen_time;
    end else if (pick < 85) begin
      r.command = CMD_SNAPSHOT;
      r.time_us = gen_time + snapshot_offset();
    end else if (pick < 90) begin
      r.command = CMD_CLEAR;
      r.time_us = gen_time + $urandom_range(5000);
    end else if (pick < 93) begin
      r.command = CMD_UNUSED;
      r.time_us = $urandom;
    end else begin
      r.command = CMD_PULSE;
      gen_time = $urandom;
      r.time_us = gen_time;
    end
    return r;
  endfunction

  // Register write, shadow updated alongside (the block is idle meanwhile).
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DEBOUNCE:   cfg_debounce = val;
      CFG_TIMEOUT:    cfg_timeout = val;
      CFG_TARGET_MIN: cfg_rpm_min = val[RpmW-1:0];
      CFG_TARGET_MAX: cfg_rpm_max = val[RpmW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(int sel);
    case (sel)
      // nominal: the reset values written explicitly, plus a dead index
      0: begin
        write_reg(CFG_DEBOUNCE, 32'd1000);
        write_reg(CFG_TIMEOUT, 32'd1000000);
        write_reg(CFG_TARGET_MIN, 32'd1000);
        write_reg(CFG_TARGET_MAX, 32'd3000);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
      end
      // no debounce, never stale, whole rpm range in band
      1: begin
        write_reg(CFG_DEBOUNCE, 32'd0);
        write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(CFG_TARGET_MIN, 32'd0);
        write_reg(CFG_TARGET_MAX, 32'd60000000);
      end
      // longest debounce, zero timeout, min above max
      2: begin
        write_reg(CFG_DEBOUNCE, 32'hFFFF_FFFF);
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_TARGET_MIN, 32'd3000);
        write_reg(CFG_TARGET_MAX, 32'd1000);
      end
      // min above max with speed usually known
      3: begin
        write_reg(CFG_DEBOUNCE, 32'd5000);
        write_reg(CFG_TIMEOUT, 32'd200000);
        write_reg(CFG_TARGET_MIN, 32'd2500);
        write_reg(CFG_TARGET_MAX, 32'd2000);
      end
      // both bounds at 60000000 rpm, the rpm of a one-microsecond period
      4: begin
        write_reg(CFG_DEBOUNCE, 32'd1);
        write_reg(CFG_TIMEOUT, 32'd30000);
        write_reg(CFG_TARGET_MIN, 32'd60000000);
        write_reg(CFG_TARGET_MAX, 32'd60000000);
      end
      // both bounds at zero: only unknown speed counts as in band
      default: begin
        write_reg(CFG_DEBOUNCE, 32'd20000);
        write_reg(CFG_TIMEOUT, 32'd1000000);
        write_reg(CFG_TARGET_MIN, 32'd0);
        write_reg(CFG_TARGET_MAX, 32'd0);
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender pause: nothing more is offered until every owed snapshot is back.
  task automatic wait_drain();
    do @(negedge clk);
    while (request_q.size() != 0 || req_ch.valid || snapshot_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_PULSE;
    req_ch.time_us = '0;
    req_ch.clear_pending = 1'b0;
    rsp_ch.ready = 1'b0;

    cfg_debounce = DebounceRst;
    cfg_timeout = TimeoutRst;
    cfg_rpm_min = TargetMinRst;
    cfg_rpm_max = TargetMaxRst;
    trk_last = '0;
    trk_period = '0;
    trk_accepts = '0;
    trk_rejects = '0;
    trk_pending = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on reset defaults: debounce 1000 us, timeout 1 s,
    // band 1000..3000 rpm.
    push_req(CMD_SNAPSHOT, 32'd5, 1'b1);            // nothing recorded, ack with nothing pending
    push_req(CMD_PULSE, 32'd0, 1'b0);               // pulse at time zero stores "no pulse"
    push_req(CMD_PULSE, 32'd500, 1'b0);             // so this one skips debounce, no period
    push_req(CMD_PULSE, 32'd1499, 1'b0);            // one short of debounce: rejected
    push_req(CMD_PULSE, 32'd1500, 1'b0);            // exactly debounce: seeds the period
    push_req(CMD_PULSE, 32'd31500, 1'b1);           // ack bit on a pulse is ignored
    push_req(CMD_SNAPSHOT, 32'd1031500, 1'b0);      // age equals timeout: still current
    push_req(CMD_SNAPSHOT, 32'd1031501, 1'b1);      // one past timeout: stale, ack
    push_req(CMD_SNAPSHOT, 32'd31600, 1'b0);        // flag now reads clear
    push_req(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);      // unused code: snapshot only, ack ignored
    push_req(CMD_PULSE, 32'hFFFF_FFFF, 1'b0);       // top timestamp, huge gap into the average
    push_req(CMD_PULSE, 32'd29999, 1'b0);           // wraps through zero
    push_req(CMD_PULSE, 32'd59999, 1'b0);
    push_req(CMD_PULSE, 32'd89999, 1'b0);
    push_req(CMD_PULSE, 32'd119999, 1'b0);
    push_req(CMD_CLEAR, 32'd120000, 1'b1);          // everything back to zero
    push_req(CMD_SNAPSHOT, 32'd120500, 1'b0);
    push_req(CMD_PULSE, 32'h8000_0000, 1'b0);
    push_req(CMD_PULSE, 32'h8000_4E20, 1'b0);       // 20 ms seed: exactly 3000 rpm, top of band
    push_req(CMD_SNAPSHOT, 32'h8000_4E20, 1'b0);
    push_req(CMD_PULSE, 32'hFFFF_FFFE, 1'b0);
    push_req(CMD_SNAPSHOT, 32'hFFFF_FFFE, 1'b1);
    wait_drain();

    // Random batches, one register setting each. Idling: sender-light /
    // receiver-heavy, then the reverse, then none (with the long hold-off).
    gen_time = 32'hFFF0_0000;
    for (int b = 0; b < NumSettings; b++) begin
      if (b < 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 66;
      end else if (b < 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_setting(b);
      if (b == 4) hold_seq++;
      for (int i = 0; i < BatchRequests; i++) request_q.push_back(random_request());
      wait_drain();
    end

    repeat (ResultLatency + 10) @(posedge clk);

    $display("Covered %0d requests over %0d register settings: %0d pulses accepted, %0d rejected.",
             n_requests, NumSettings + 1, n_accepted, n_rejected);
    $display("%0d snapshots with current speed, %0d of them in band; %0d results checked.",
             n_current, n_in_band, n_results);
    if (mismatches == 0) begin
      $display("[debounced_tachometer_tracker] OK");
    end else begin
      $display("[debounced_tachometer_tracker] ERROR");
    end
    $finish;
  end

endmodule
